/* rtl/core/gdc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pkg
// Types, register indexes and helpers shared by the green-difference codec.
// ----------------------------------------------------------------------------
package gdc_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned COL_W    = 18;
   localparam int unsigned ROW_W    = 24;
   localparam int unsigned RUN_W    = 16;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN   = 2'd3;

   localparam logic [1:0] GROUP_NONE  = 2'd0;
   localparam logic [1:0] GROUP_ONE   = 2'd1;
   localparam logic [1:0] GROUP_THREE = 2'd3;

   typedef enum logic [1:0] {
      PHASE_FIRST  = 2'd0,
      PHASE_SECOND = 2'd1,
      PHASE_THIRD  = 2'd2
   } gdc_phase_type;

   typedef struct packed {
      logic               direction;
      logic [COL_W-1:0]   len;
      logic [COL_W-1:0]   pix_end;
      logic [ROW_W-1:0]   row_count;
      logic [RUN_W-1:0]   min_run;
   } gdc_cfg_type;

   typedef struct packed {
      logic [1:0]         count;
      logic [BYTE_W-1:0]  b0;
      logic [BYTE_W-1:0]  b1;
      logic [BYTE_W-1:0]  b2;
   } gdc_group_type;

   // remainder of an 18-bit value by three, using 4 == 1 mod 3
   function automatic logic [1:0] mod3_col(input logic [COL_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [1:0] m;
      s = '0;
      for (int i = 0; i < 9; i++) begin
         s = s + 5'(v[2*i +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      case (t) inside
         3'd0, 3'd3, 3'd6: m = 2'd0;
         3'd1, 3'd4, 3'd7: m = 2'd1;
         default:          m = 2'd2;
      endcase
      return m;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/gdc_pixel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_pixel
// Per-pixel green-difference transform with RGB565 run detection and
// low-bit cleanup, for both encode and decode.
// ----------------------------------------------------------------------------
module gdc_pixel (
   input  wire logic                         direction,
   input  wire logic                         detect,
   input  wire logic [gdc_pkg::RUN_W-1:0]    run,
   input  wire logic [gdc_pkg::RUN_W-1:0]    min_run,
   input  wire logic [gdc_pkg::BYTE_W-1:0]   first,
   input  wire logic [gdc_pkg::BYTE_W-1:0]   second,
   input  wire logic [gdc_pkg::BYTE_W-1:0]   third,
   output logic      [gdc_pkg::BYTE_W-1:0]   out0,
   output logic      [gdc_pkg::BYTE_W-1:0]   out1,
   output logic      [gdc_pkg::BYTE_W-1:0]   out2,
   output logic      [gdc_pkg::RUN_W-1:0]    run_next,
   output logic                              detect_next
);

   localparam logic [gdc_pkg::RUN_W-1:0] RUN_MAX = 16'hFFFF;

   function automatic logic [7:0] rb_fix(input logic [7:0] v);
      return v ^ {5'b0, {3{v[3]}}};
   endfunction

   function automatic logic [7:0] g_fix(input logic [7:0] v);
      return v ^ {6'b0, {2{v[2]}}};
   endfunction

   function automatic logic looks_565(input logic [7:0] b, input logic [7:0] g,
                                      input logic [7:0] r);
      return (b[2:0] == {3{b[3]}}) && (g[1:0] == {2{g[2]}}) &&
             (r[2:0] == {3{r[3]}});
   endfunction

   function automatic logic [15:0] run_step(input logic [15:0] v, input logic m);
      logic [15:0] n;
      if (!m) begin
         n = '0;
      end else if (v == RUN_MAX) begin
         n = v;
      end else begin
         n = v + 16'd1;
      end
      return n;
   endfunction

   logic [7:0]  enc_b, enc_g, enc_r;
   logic [7:0]  dec_b, dec_g, dec_r;
   logic [7:0]  dec_b_raw, dec_r_raw;
   logic [15:0] enc_run, dec_run;
   logic        enc_apply, dec_apply;

   always_comb begin
      enc_run   = run_step(run, looks_565(first, second, third));
      enc_apply = detect && ((enc_run > min_run) || (run >= min_run));
      enc_b     = enc_apply ? rb_fix(first)  : first;
      enc_g     = enc_apply ? g_fix(second)  : second;
      enc_r     = enc_apply ? rb_fix(third)  : third;

      dec_r_raw = first - second;
      dec_b_raw = first - third;
      dec_apply = detect && (run >= min_run);
      dec_b     = dec_apply ? rb_fix(dec_b_raw) : dec_b_raw;
      dec_g     = dec_apply ? g_fix(first)      : first;
      dec_r     = dec_apply ? rb_fix(dec_r_raw) : dec_r_raw;
      dec_run   = run_step(run, looks_565(dec_b, dec_g, dec_r));

      if (!direction) begin
         out0     = enc_g;
         out1     = enc_g - enc_r;
         out2     = enc_g - enc_b;
         run_next = detect ? enc_run : run;
      end else begin
         out0     = dec_b;
         out1     = dec_g;
         out2     = dec_r;
         run_next = detect ? dec_run : run;
      end
      detect_next = detect && (run_next != '0);
   end

endmodule
`default_nettype wire

/* rtl/core/gdc_track.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_track
// Row, column and pixel phase tracking; holds the first two bytes of a pixel
// and the run state, and forms the result group of each accepted byte.
// ----------------------------------------------------------------------------
module gdc_track (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gdc_pkg::gdc_cfg_type          cfg,
   input  wire logic                          accept,
   input  wire logic [gdc_pkg::BYTE_W-1:0]    byte_in,
   output gdc_pkg::gdc_group_type             group
);

   gdc_pkg::gdc_phase_type      phase_ff, phase_in;
   logic [gdc_pkg::BYTE_W-1:0]  held_first_ff, held_first_in;
   logic [gdc_pkg::BYTE_W-1:0]  held_second_ff, held_second_in;
   logic [gdc_pkg::COL_W-1:0]   column_ff, column_in;
   logic [gdc_pkg::ROW_W-1:0]   rows_ff, rows_in;
   logic [gdc_pkg::RUN_W-1:0]   run_ff, run_in;
   logic                        detect_ff, detect_in;

   logic                        finished, in_pix;
   logic [gdc_pkg::COL_W:0]     col_inc;
   logic [gdc_pkg::BYTE_W-1:0]  px0, px1, px2;
   logic [gdc_pkg::RUN_W-1:0]   px_run;
   logic                        px_detect;

   gdc_pixel u_pixel (
      .direction   (cfg.direction),
      .detect      (detect_ff),
      .run         (run_ff),
      .min_run     (cfg.min_run),
      .first       (held_first_ff),
      .second      (held_second_ff),
      .third       (byte_in),
      .out0        (px0),
      .out1        (px1),
      .out2        (px2),
      .run_next    (px_run),
      .detect_next (px_detect)
   );

   always_comb begin
      finished = rows_ff >= cfg.row_count;
      in_pix   = column_ff < cfg.pix_end;
      col_inc  = {1'b0, column_ff} + 19'd1;

      group.b0 = in_pix ? px0 : byte_in;
      group.b1 = px1;
      group.b2 = px2;
      if (finished) begin
         group.count = gdc_pkg::GROUP_NONE;
      end else if (!in_pix) begin
         group.count = gdc_pkg::GROUP_ONE;
      end else if (phase_ff inside {gdc_pkg::PHASE_FIRST, gdc_pkg::PHASE_SECOND}) begin
         group.count = gdc_pkg::GROUP_NONE;
      end else begin
         group.count = gdc_pkg::GROUP_THREE;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      column_in      = column_ff;
      rows_in        = rows_ff;
      run_in         = run_ff;
      detect_in      = detect_ff;
      if (accept && !finished) begin
         if (in_pix) begin
            case (phase_ff)
               gdc_pkg::PHASE_FIRST: begin
                  held_first_in = byte_in;
                  phase_in      = gdc_pkg::PHASE_SECOND;
               end
               gdc_pkg::PHASE_SECOND: begin
                  held_second_in = byte_in;
                  phase_in       = gdc_pkg::PHASE_THIRD;
               end
               default: begin
                  phase_in  = gdc_pkg::PHASE_FIRST;
                  run_in    = px_run;
                  detect_in = px_detect;
               end
            endcase
         end
         if (col_inc >= {1'b0, cfg.len}) begin
            column_in = '0;
            phase_in  = gdc_pkg::PHASE_FIRST;
            rows_in   = rows_ff + 24'd1;
         end else begin
            column_in = col_inc[gdc_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= gdc_pkg::PHASE_FIRST;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         column_ff      <= '0;
         rows_ff        <= '0;
         run_ff         <= '0;
         detect_ff      <= 1'b1;
      end else begin
         phase_ff       <= phase_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         column_ff      <= column_in;
         rows_ff        <= rows_in;
         run_ff         <= run_in;
         detect_ff      <= detect_in;
      end
   end

   a_detect_sticky: assert property (@(posedge clock) disable iff (reset)
      !detect_ff |=> !detect_ff)
      else $error("run detection came back on");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == gdc_pkg::PHASE_FIRST || phase_ff == gdc_pkg::PHASE_SECOND ||
      phase_ff == gdc_pkg::PHASE_THIRD)
      else $error("pixel phase out of range");

   a_pixel_in_row: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != gdc_pkg::PHASE_FIRST) |-> (column_ff != '0))
      else $error("pixel phase set at row start");

endmodule
`default_nettype wire

/* rtl/core/gdc_serial.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gdc_serial
// Result register: holds one group of up to three bytes and hands them out
// one word per cycle while the receiver is ready, marking the last of the group.
// ----------------------------------------------------------------------------
module gdc_serial (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire gdc_pkg::gdc_group_type        group,
   output logic                               can_load,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [gdc_pkg::BYTE_W-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);

   logic [gdc_pkg::BYTE_W-1:0] slot_ff [3];
   logic [gdc_pkg::BYTE_W-1:0] slot_in [3];
   logic [1:0]                 count_ff, count_in;
   logic                       pop;

   always_comb begin
      rsp_tvalid = count_ff != 2'd0;
      rsp_tdata  = slot_ff[0];
      rsp_tlast  = count_ff == 2'd1;
      pop        = rsp_tvalid && rsp_tready;
      can_load   = (count_ff == 2'd0) || (count_ff == 2'd1 && rsp_tready);

      slot_in  = slot_ff;
      count_in = count_ff;
      if (load) begin
         slot_in[0] = group.b0;
         slot_in[1] = group.b1;
         slot_in[2] = group.b2;
         count_in   = group.count;
      end else if (pop) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         count_in   = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == 2'd0 || (count_ff == 2'd1 && pop)))
      else $error("group loaded over pending words");

   a_group_size: assert property (@(posedge clock) disable iff (reset)
      load |-> (group.count == gdc_pkg::GROUP_ONE || group.count == gdc_pkg::GROUP_THREE))
      else $error("bad group size");

   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && rsp_tlast && !load) |=> !rsp_tvalid)
      else $error("words left after last of group");

endmodule
`default_nettype wire

/* rtl/core/rgb24_green_difference_codec_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgb24_green_difference_codec_top
// Green-difference color codec for 24-bit pixel byte streams.
// ----------------------------------------------------------------------------
// One byte is accepted per cycle. The first two bytes of a pixel and bytes
// after the last row give no word; a pixel's third byte gives three words
// and a padding byte one, leaving through the result register at one word
// per cycle while the receiver is ready, and a new byte is taken while the
// last word of the previous group is taken. A byte that gives words waits
// while the result register holds words, unless only its final word is
// left and that word is taken in the same cycle. Configuration writes are
// always accepted.
module rgb24_green_difference_codec_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // byte_in[7:0]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [7:0]                        rsp_tdata,   // byte_out[7:0]
   output logic                                   rsp_tlast,   // final_of_group
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [gdc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [gdc_pkg::CSR_DATA_W-1:0]    csr_data
);

   gdc_pkg::gdc_cfg_type   cfg_ff, cfg_in;
   gdc_pkg::gdc_group_type group;
   logic                   can_load, accept;
   logic [gdc_pkg::COL_W-1:0] new_len;

   always_comb begin
      csr_ready = 1'b1;
      new_len   = (csr_data[gdc_pkg::COL_W-1:0] == '0) ? 18'd1
                                                       : csr_data[gdc_pkg::COL_W-1:0];
      cfg_in    = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            gdc_pkg::CSR_DIRECTION: cfg_in.direction = csr_data[0];
            gdc_pkg::CSR_ROW_BYTES: begin
               cfg_in.len     = new_len;
               cfg_in.pix_end = new_len - 18'(gdc_pkg::mod3_col(new_len));
            end
            gdc_pkg::CSR_ROW_COUNT: cfg_in.row_count = csr_data;
            gdc_pkg::CSR_MIN_RUN:   cfg_in.min_run   = csr_data[gdc_pkg::RUN_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction <= 1'b0;
         cfg_ff.len       <= 18'd3;
         cfg_ff.pix_end   <= 18'd3;
         cfg_ff.row_count <= 24'd1;
         cfg_ff.min_run   <= 16'd63;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      req_tready = (group.count == gdc_pkg::GROUP_NONE) || can_load;
      accept     = req_tvalid && req_tready;
   end

   gdc_track u_track (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .accept  (accept),
      .byte_in (req_tdata),
      .group   (group)
   );

   gdc_serial u_serial (
      .clock      (clock),
      .reset      (reset),
      .load       (accept && group.count != gdc_pkg::GROUP_NONE),
      .group      (group),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_pix_end_aligned: assert property (@(posedge clock) disable iff (reset)
      (cfg_ff.pix_end <= cfg_ff.len) && (cfg_ff.len - cfg_ff.pix_end < 18'd3))
      else $error("pixel area does not match row length");

   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      cfg_ff.len != '0)
      else $error("zero row length");

   a_stall_only_busy: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result register");

endmodule
`default_nettype wire

/* sim/rgb24_green_difference_codec_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb24_green_difference_codec_top_tb
// Self-checking bench for the green-difference byte stream codec.
// ----------------------------------------------------------------------------
// Bytes are fed from a queue by a clocked driver. A clocked monitor runs a
// behavioral copy of the codec on every accepted byte and checks each
// returned word, data and last flag, against the oldest prediction.
// Directed pixels walk the RGB565 run detector through cleanup and its
// final break; random phases then vary direction, row length, row limit
// and the idle pattern on both channels.
// ----------------------------------------------------------------------------
module rgb24_green_difference_codec_top_tb;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned LONG_RUN_PIXELS = 6;
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   typedef enum logic [1:0] {SLOT_FIRST, SLOT_SECOND, SLOT_THIRD} pixel_slot_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } codec_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [gdc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gdc_pkg::CSR_DATA_W-1:0] csr_data = '0;

   logic [7:0]      pending_bytes[$];
   codec_word_type  expected_words[$];

   logic         cfg_decode = DIR_ENCODE;
   logic [17:0]  cfg_row_bytes = 18'd3;
   logic [23:0]  cfg_row_count = 24'd1;
   logic [15:0]  cfg_min_run = 16'd63;

   pixel_slot_type m_slot = SLOT_FIRST;
   logic [7:0]   m_first = '0;
   logic [7:0]   m_second = '0;
   int unsigned  m_col = 0;
   logic [23:0]  m_rows = '0;
   logic [15:0]  m_run = '0;
   logic         m_detect = 1'b1;

   int unsigned  cycle_count = 0;
   int unsigned  error_count = 0;
   logic         req_taken = 1'b0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_gap = 0;
   int unsigned  rsp_hold = 0;
   bit           hold_off_start = 1'b0;
   bit           idle_on = 1'b0;
   int unsigned  req_idle_pct = 0;
   int unsigned  rsp_idle_pct = 0;

   rgb24_green_difference_codec_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [2:0] rb_low_mask(input logic [7:0] v);
      return v[3] ? 3'd7 : 3'd0;
   endfunction

   function automatic logic [1:0] g_low_mask(input logic [7:0] v);
      return v[2] ? 2'd3 : 2'd0;
   endfunction

   function automatic bit is_565_pixel(input logic [7:0] b, input logic [7:0] g,
                                       input logic [7:0] r);
      return b[2:0] == rb_low_mask(b) && g[1:0] == g_low_mask(g) &&
             r[2:0] == rb_low_mask(r);
   endfunction

   function automatic logic [15:0] next_run(input logic [15:0] run, input bit match);
      if (!match) return 16'd0;
      return (run == 16'hFFFF) ? run : run + 16'd1;
   endfunction

   function automatic logic [7:0] snap_565(input logic [7:0] v, input bit green);
      if (green) return v[2] ? (v | 8'h03) : (v & 8'hFC);
      return v[3] ? (v | 8'h07) : (v & 8'hF8);
   endfunction

   task automatic push_codec_words(input logic [7:0] in_byte);
      int unsigned len;
      int unsigned pix_end;
      logic [7:0]  b;
      logic [7:0]  g;
      logic [7:0]  r;
      logic [15:0] old_run;
      bit          clean;
      len = (cfg_row_bytes == 0) ? 1 : cfg_row_bytes;
      pix_end = (len / 3) * 3;
      if (m_rows >= cfg_row_count) return;
      if (m_col < pix_end) begin
         case (m_slot)
            SLOT_FIRST: begin
               m_first = in_byte;
               m_slot = SLOT_SECOND;
            end
            SLOT_SECOND: begin
               m_second = in_byte;
               m_slot = SLOT_THIRD;
            end
            default: begin
               m_slot = SLOT_FIRST;
               if (cfg_decode == DIR_ENCODE) begin
                  b = m_first;
                  g = m_second;
                  r = in_byte;
                  if (m_detect) begin
                     old_run = m_run;
                     m_run = next_run(old_run, is_565_pixel(b, g, r));
                     clean = m_run > cfg_min_run || old_run >= cfg_min_run;
                     if (clean) begin
                        b ^= 8'(rb_low_mask(b));
                        g ^= 8'(g_low_mask(g));
                        r ^= 8'(rb_low_mask(r));
                     end
                     m_detect = m_run != 0;
                  end
                  expected_words.push_back('{data: g, last: 1'b0});
                  expected_words.push_back('{data: 8'(g - r), last: 1'b0});
                  expected_words.push_back('{data: 8'(g - b), last: 1'b1});
               end else begin
                  g = m_first;
                  r = 8'(g - m_second);
                  b = 8'(g - in_byte);
                  if (m_detect) begin
                     if (m_run >= cfg_min_run) begin
                        b ^= 8'(rb_low_mask(b));
                        g ^= 8'(g_low_mask(g));
                        r ^= 8'(rb_low_mask(r));
                     end
                     m_run = next_run(m_run, is_565_pixel(b, g, r));
                     m_detect = m_run != 0;
                  end
                  expected_words.push_back('{data: b, last: 1'b0});
                  expected_words.push_back('{data: g, last: 1'b0});
                  expected_words.push_back('{data: r, last: 1'b1});
               end
            end
         endcase
      end else begin
         expected_words.push_back('{data: in_byte, last: 1'b1});
      end
      m_col++;
      if (m_col >= len) begin
         m_col = 0;
         m_slot = SLOT_FIRST;
         m_rows = m_rows + 24'd1;
      end
   endtask

   task automatic note_failure(input string what, input codec_word_type want,
                               input codec_word_type got);
      error_count++;
      if (error_count <= 10)
         $display("%0t %s: expected data=%h last=%b, got data=%h last=%b",
                  $realtime, what, want.data, want.last, got.data, got.last);
   endtask

   // driver: hold an offered word until taken, then advance or idle
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < req_idle_pct) begin
         req_gap <= $urandom_range(0, 18);
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata <= pending_bytes[0];
      end
   end

   // receiver: long hold-off on request, else random stall bursts
   always @(negedge clock) begin
      if (hold_off_start) begin
         hold_off_start = 1'b0;
         rsp_hold = HOLD_OFF_CYCLES;
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < rsp_idle_pct) begin
         rsp_gap = $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      codec_word_type want;
      codec_word_type got;
      cycle_count++;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{data: rsp_tdata, last: rsp_tlast};
         if (expected_words.size() == 0) begin
            note_failure("unexpected word", '0, got);
         end else begin
            want = expected_words.pop_front();
            if (got.data !== want.data || got.last !== want.last)
               note_failure("word mismatch", want, got);
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         push_codec_words(req_tdata);
         void'(pending_bytes.pop_front());
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_csr(input logic [gdc_pkg::CSR_IDX_W-1:0] reg_index,
                            input logic [gdc_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (reg_index)
         gdc_pkg::CSR_DIRECTION: cfg_decode = value[0];
         gdc_pkg::CSR_ROW_BYTES: cfg_row_bytes = value[17:0];
         gdc_pkg::CSR_ROW_COUNT: cfg_row_count = value[23:0];
         gdc_pkg::CSR_MIN_RUN:   cfg_min_run = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain_codec();
      while (pending_bytes.size() != 0 || expected_words.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_raw_pixel(input logic [7:0] b, input logic [7:0] g,
                                  input logic [7:0] r);
      pending_bytes.push_back(b);
      pending_bytes.push_back(g);
      pending_bytes.push_back(r);
   endtask

   task automatic queue_coded_pixel(input logic [7:0] b, input logic [7:0] g,
                                    input logic [7:0] r);
      pending_bytes.push_back(g);
      pending_bytes.push_back(8'(g - r));
      pending_bytes.push_back(8'(g - b));
   endtask

   // flipped: store the pattern with its low bits toggled, as decode cleanup expects
   task automatic queue_565_pixel(input bit coded, input bit flipped);
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      b = snap_565(8'($urandom_range(0, 255)), 1'b0);
      g = snap_565(8'($urandom_range(0, 255)), 1'b1);
      r = snap_565(8'($urandom_range(0, 255)), 1'b0);
      if (flipped) begin
         b ^= 8'(rb_low_mask(b));
         g ^= 8'(g_low_mask(g));
         r ^= 8'(rb_low_mask(r));
      end
      if (coded) queue_coded_pixel(b, g, r);
      else queue_raw_pixel(b, g, r);
   endtask

   initial begin
      int unsigned phase_idx;
      int unsigned batch;
      int unsigned row_len;
      int unsigned rows_left;
      int unsigned pick;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_on = 1'b1;
      req_idle_pct = 20;
      rsp_idle_pct = 20;

      // reset settings: one row of one pixel, later bytes dropped
      queue_raw_pixel(8'hFF, 8'hFF, 8'hFF);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      drain_codec();

      write_csr(gdc_pkg::CSR_ROW_COUNT, 24'hFFFFFF);
      write_csr(gdc_pkg::CSR_ROW_BYTES, 24'd262143);
      write_csr(gdc_pkg::CSR_MIN_RUN, 24'd2);
      queue_raw_pixel(8'h00, 8'h00, 8'h00);
      queue_565_pixel(1'b0, 1'b0);
      queue_565_pixel(1'b0, 1'b0);
      drain_codec();

      write_csr(gdc_pkg::CSR_DIRECTION, 24'(DIR_DECODE));
      queue_coded_pixel(8'hF8, 8'hFC, 8'hF8);
      queue_565_pixel(1'b1, 1'b1);
      drain_codec();

      // matching run: reach the cleanup threshold and run past it
      idle_on = 1'b0;
      write_csr(gdc_pkg::CSR_DIRECTION, 24'(DIR_ENCODE));
      write_csr(gdc_pkg::CSR_MIN_RUN, 24'd4);
      for (int unsigned k = 0; k < LONG_RUN_PIXELS; k++) queue_565_pixel(1'b0, 1'b0);
      drain_codec();

      idle_on = 1'b1;
      write_csr(gdc_pkg::CSR_DIRECTION, 24'(DIR_DECODE));
      write_csr(gdc_pkg::CSR_MIN_RUN, 24'd0);
      queue_565_pixel(1'b1, 1'b1);
      drain_codec();

      // break the run: cleanup still applies once, then detection stays off
      write_csr(gdc_pkg::CSR_DIRECTION, 24'(DIR_ENCODE));
      queue_raw_pixel(8'h08, 8'h04, 8'h0C);
      queue_raw_pixel(8'hFF, 8'hFF, 8'hFF);
      drain_codec();

      // shrink the row below the current column, then short and empty rows
      write_csr(gdc_pkg::CSR_ROW_BYTES, 24'd4);
      pending_bytes.push_back(8'hA5);
      queue_raw_pixel(8'h12, 8'h34, 8'h56);
      pending_bytes.push_back(8'h5A);
      drain_codec();
      write_csr(gdc_pkg::CSR_ROW_BYTES, 24'd0);
      pending_bytes.push_back(8'h80);
      drain_codec();
      write_csr(gdc_pkg::CSR_ROW_COUNT, 24'd0);
      pending_bytes.push_back(8'h7F);
      drain_codec();

      for (phase_idx = 0; phase_idx < 12; phase_idx++) begin
         idle_on = phase_idx < 10;
         req_idle_pct = (phase_idx == 3) ? 0 : $urandom_range(5, 40);
         rsp_idle_pct = (phase_idx == 3) ? 0 : $urandom_range(5, 40);
         write_csr(gdc_pkg::CSR_DIRECTION,
                   $urandom_range(0, 1) ? 24'(DIR_DECODE) : 24'(DIR_ENCODE));
         pick = $urandom_range(0, 9);
         if (pick < 6) row_len = $urandom_range(3, 12);
         else if (pick == 6) row_len = $urandom_range(0, 2);
         else if (pick == 7) row_len = 262143;
         else row_len = $urandom_range(13, 262143);
         write_csr(gdc_pkg::CSR_ROW_BYTES, 24'(row_len));
         write_csr(gdc_pkg::CSR_MIN_RUN, 24'($urandom_range(0, 65535)));
         batch = (phase_idx == 5) ? 60 : $urandom_range(12, 28);
         rows_left = batch / ((row_len == 0) ? 1 : row_len) + 2;
         if (phase_idx % 5 == 4) rows_left = $urandom_range(0, 2);
         write_csr(gdc_pkg::CSR_ROW_COUNT, m_rows + 24'(rows_left));
         if (phase_idx == 5) hold_off_start = 1'b1;
         for (int unsigned k = 0; k < batch; k++)
            pending_bytes.push_back(8'($urandom_range(0, 255)));
         drain_codec();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
